>>> rtl/nirdec_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR pulse decoder package
// Shared constants, register map, configuration and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package nirdec_pkg;

    // Segment window and frame geometry.
    localparam logic [15:0] MIN_SEGMENT_US = 16'd100;
    localparam logic [15:0] MAX_SEGMENT_US = 16'd20000;
    localparam logic [6:0]  REPEAT_LEN     = 7'd3;
    localparam logic [6:0]  SHORT_LEN      = 7'd67;
    localparam logic [6:0]  LONG_LEN       = 7'd71;
    localparam logic [6:0]  FRAME_LAST_POS = 7'd70;
    localparam logic [6:0]  FIRST_BIT_POS  = 7'd3;
    localparam logic [6:0]  LAST_BIT_POS   = 7'd65;
    localparam logic [6:0]  PCT_SCALE      = 7'd100;
    localparam int          LEAD_COUNT     = 3;

    // Register map, word index.
    localparam int          REG_IDX_W         = 3;
    localparam int          PADDR_W           = REG_IDX_W + 2;
    localparam logic [2:0]  REG_HDR_MARK      = 3'd0;
    localparam logic [2:0]  REG_HDR_SPACE     = 3'd1;
    localparam logic [2:0]  REG_RPT_FIRST     = 3'd2;
    localparam logic [2:0]  REG_RPT_SECOND    = 3'd3;
    localparam logic [2:0]  REG_RPT_THIRD     = 3'd4;
    localparam logic [2:0]  REG_TOLERANCE     = 3'd5;
    localparam logic [2:0]  REG_DEV_ADDRESS   = 3'd6;
    localparam logic [2:0]  REG_BIT_THRESHOLD = 3'd7;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [15:0] header_mark_us;
        logic [15:0] header_space_us;
        logic [15:0] repeat_first_us;
        logic [15:0] repeat_second_us;
        logic [15:0] repeat_third_us;
        logic [6:0]  tolerance_percent;
        logic [7:0]  device_address;
        logic [15:0] bit_threshold_us;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       update;
        logic       mul;
        logic       cmp;
        logic [1:0] step;
        logic       finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
        logic out_free;
    } t_dp_stat;

endpackage : nirdec_pkg

`default_nettype wire

>>> rtl/nirdec_seg_if.sv
// ----------------------------------------------------------------------------
// Segment channel
// Valid/ready channel carrying one measured segment duration per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface nirdec_seg_if;
    logic        valid;
    logic        ready;
    logic [15:0] segment_us;

    modport source (output valid, output segment_us, input ready);
    modport sink   (input valid, input segment_us, output ready);
endinterface : nirdec_seg_if

`default_nettype wire

>>> rtl/nirdec_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one decoded frame result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface nirdec_res_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic       is_repeat;
    logic [7:0] key_code;

    modport source (output valid, output frame_ok, output is_repeat, output key_code,
                    input ready);
    modport sink   (input valid, input frame_ok, input is_repeat, input key_code,
                    output ready);
endinterface : nirdec_res_if

`default_nettype wire

>>> rtl/nirdec_regs.sv
// ----------------------------------------------------------------------------
// NEC IR decoder register file
// APB-style configuration registers with reset defaults and read back.
// ----------------------------------------------------------------------------
`default_nettype none

module nirdec_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [nirdec_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output nirdec_pkg::t_cfg                  o_cfg
);
    import nirdec_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // Register writes; reset loads the nominal NEC timings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mark_us    <= 16'd9000;
            r_cfg.header_space_us   <= 16'd4500;
            r_cfg.repeat_first_us   <= 16'd9000;
            r_cfg.repeat_second_us  <= 16'd2250;
            r_cfg.repeat_third_us   <= 16'd560;
            r_cfg.tolerance_percent <= 7'd20;
            r_cfg.device_address    <= 8'd0;
            r_cfg.bit_threshold_us  <= 16'd1000;
        end else if (wr_en) begin
            unique case (idx)
                REG_HDR_MARK:      r_cfg.header_mark_us    <= pwdata[15:0];
                REG_HDR_SPACE:     r_cfg.header_space_us   <= pwdata[15:0];
                REG_RPT_FIRST:     r_cfg.repeat_first_us   <= pwdata[15:0];
                REG_RPT_SECOND:    r_cfg.repeat_second_us  <= pwdata[15:0];
                REG_RPT_THIRD:     r_cfg.repeat_third_us   <= pwdata[15:0];
                REG_TOLERANCE:     r_cfg.tolerance_percent <= pwdata[6:0];
                REG_DEV_ADDRESS:   r_cfg.device_address    <= pwdata[7:0];
                REG_BIT_THRESHOLD: r_cfg.bit_threshold_us  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back, zero extended.
    always_comb begin
        unique case (idx)
            REG_HDR_MARK:      prdata = {16'd0, r_cfg.header_mark_us};
            REG_HDR_SPACE:     prdata = {16'd0, r_cfg.header_space_us};
            REG_RPT_FIRST:     prdata = {16'd0, r_cfg.repeat_first_us};
            REG_RPT_SECOND:    prdata = {16'd0, r_cfg.repeat_second_us};
            REG_RPT_THIRD:     prdata = {16'd0, r_cfg.repeat_third_us};
            REG_TOLERANCE:     prdata = {25'd0, r_cfg.tolerance_percent};
            REG_DEV_ADDRESS:   prdata = {24'd0, r_cfg.device_address};
            REG_BIT_THRESHOLD: prdata = {16'd0, r_cfg.bit_threshold_us};
            default:           prdata = 32'd0;
        endcase
    end

endmodule : nirdec_regs

`default_nettype wire

>>> rtl/nirdec_ctrl.sv
// ----------------------------------------------------------------------------
// NEC IR decoder controller
// Sequences segment intake, the tolerance checks and the result write.
// ----------------------------------------------------------------------------
`default_nettype none

module nirdec_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire nirdec_pkg::t_dp_stat i_stat,
    output nirdec_pkg::t_dp_cmd       o_cmd
);
    import nirdec_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [1:0] LAST_STEP = 2'(LEAD_COUNT - 1);

    logic [2:0] r_state, n_state;
    logic [1:0] r_step,  n_step;

    assign o_ready = (r_state == S_IDLE);

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.step   = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_step       = 2'd0;
                n_state      = i_stat.frame_end ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_FINISH;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A frame check always runs all steps before the result is written.
    a_finish_after_last_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (r_state == S_FINISH) && (r_step == LAST_STEP))
        else $error("result written before all tolerance steps ran");

    // Step counter stays inside the leading segment range.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= LAST_STEP)
        else $error("tolerance step out of range");

endmodule : nirdec_ctrl

`default_nettype wire

>>> rtl/nirdec_dp.sv
// ----------------------------------------------------------------------------
// NEC IR decoder datapath
// Segment counting, bit capture, shared tolerance unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nirdec_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire nirdec_pkg::t_cfg    i_cfg,
    input  wire nirdec_pkg::t_dp_cmd i_cmd,
    output nirdec_pkg::t_dp_stat     o_stat,
    input  wire logic [15:0]         i_segment_us,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_frame_ok,
    output logic                     o_is_repeat,
    output logic [7:0]               o_key_code
);
    import nirdec_pkg::*;

    // Frame state.
    logic [15:0] r_seg;
    logic [6:0]  r_count;
    logic [15:0] r_lead [LEAD_COUNT];
    logic [31:0] r_cap;
    logic [7:0]  r_last_code;

    // Tolerance unit.
    logic [23:0] r_lhs;
    logic [23:0] r_rhs;
    logic        r_pass;

    // Result register.
    logic        r_out_valid;
    logic        r_out_ok;
    logic        r_out_rep;
    logic [7:0]  r_out_key;

    logic        in_win;
    logic        is_rep;
    logic        is_data;
    logic        bit_pos;
    logic [6:0]  bit_off;
    logic [4:0]  bit_idx;
    logic [15:0] v_sel;
    logic [15:0] m_sel;
    logic [15:0] m_eff;
    logic [15:0] diff;
    logic [7:0]  tol_p1;
    logic [7:0]  b0, b1, b2, b3;
    logic        data_ok;

    assign in_win  = (r_seg >= MIN_SEGMENT_US) && (r_seg <= MAX_SEGMENT_US);
    assign is_rep  = (r_count == REPEAT_LEN);
    assign is_data = (r_count == SHORT_LEN) || (r_count == LONG_LEN);
    assign bit_pos = (r_count >= FIRST_BIT_POS) && (r_count <= LAST_BIT_POS) && r_count[0];
    assign bit_off = r_count - FIRST_BIT_POS;
    assign bit_idx = bit_off[5:1];

    assign o_stat.frame_end = in_win ? (r_count == FRAME_LAST_POS) : (r_count != 7'd0);
    assign o_stat.out_free  = !r_out_valid || i_ready;

    // Operand selection for the current tolerance step.
    always_comb begin
        unique case (i_cmd.step)
            2'd0:    v_sel = r_lead[0];
            2'd1:    v_sel = r_lead[1];
            default: v_sel = r_lead[2];
        endcase
        priority if (is_rep) begin
            unique case (i_cmd.step)
                2'd0:    m_sel = i_cfg.repeat_first_us;
                2'd1:    m_sel = i_cfg.repeat_second_us;
                default: m_sel = i_cfg.repeat_third_us;
            endcase
        end else begin
            unique case (i_cmd.step)
                2'd0:    m_sel = i_cfg.header_mark_us;
                default: m_sel = i_cfg.header_space_us;
            endcase
        end
    end

    assign m_eff  = (m_sel == 16'd0) ? 16'd1 : m_sel;
    assign diff   = (v_sel > m_eff) ? (v_sel - m_eff) : (m_eff - v_sel);
    assign tol_p1 = {1'b0, i_cfg.tolerance_percent} + 8'd1;

    // NEC byte rules on the captured bits.
    assign b0 = r_cap[7:0];
    assign b1 = r_cap[15:8];
    assign b2 = r_cap[23:16];
    assign b3 = r_cap[31:24];
    assign data_ok = r_pass && (b0 == i_cfg.device_address) &&
                     ((b1 == b0) || (b1 == ~b0)) && (b3 == ~b2);

    // Segment register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seg <= i_segment_us;
        end
    end

    // Frame state: count, leading durations, captured bits, last code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 7'd0;
            r_lead[0]   <= 16'd0;
            r_lead[1]   <= 16'd0;
            r_lead[2]   <= 16'd0;
            r_cap       <= 32'd0;
            r_last_code <= 8'd0;
        end else if (i_cmd.finish) begin
            r_count   <= 7'd0;
            r_lead[0] <= 16'd0;
            r_lead[1] <= 16'd0;
            r_lead[2] <= 16'd0;
            r_cap     <= 32'd0;
            if (is_data && data_ok) begin
                r_last_code <= b2;
            end
        end else if (i_cmd.update && in_win) begin
            if (r_count < 7'(LEAD_COUNT)) begin
                r_lead[r_count[1:0]] <= r_seg;
            end
            if (bit_pos) begin
                r_cap[bit_idx] <= (r_seg > i_cfg.bit_threshold_us);
            end
            r_count <= r_count + 7'd1;
        end
    end

    // Tolerance unit: floor(diff*100/m) <= tol is diff*100 < (tol+1)*m.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_lhs <= 24'(diff) * 24'(PCT_SCALE);
            r_rhs <= 24'(tol_p1) * 24'(m_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_pass <= 1'b1;
        end else if (i_cmd.cmp) begin
            // The header check has no third segment.
            r_pass <= r_pass && ((r_lhs < r_rhs) || (!is_rep && (i_cmd.step == 2'd2)));
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_rep <= is_rep;
            priority if (is_rep) begin
                r_out_ok  <= r_pass;
                r_out_key <= r_pass ? r_last_code : 8'd0;
            end else if (is_data && data_ok) begin
                r_out_ok  <= 1'b1;
                r_out_key <= b2;
            end else begin
                r_out_ok  <= 1'b0;
                r_out_key <= 8'd0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_frame_ok  = r_out_ok;
    assign o_is_repeat = r_out_rep;
    assign o_key_code  = r_out_key;

    // The count never runs past the longest frame.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LONG_LEN)
        else $error("segment count beyond longest frame");

    // Frame end returns the frame state to empty.
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count == 7'd0) && (r_cap == 32'd0))
        else $error("frame state not cleared at frame end");

    // An accepted repeat carries the stored last code.
    a_repeat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok && r_out_rep) |-> (r_out_key == r_last_code))
        else $error("repeat result differs from last code");

endmodule : nirdec_dp

`default_nettype wire

>>> rtl/nec_ir_pulse_decoder_core.sv
// ----------------------------------------------------------------------------
// NEC IR pulse decoder core
// Decodes NEC frames and repeats from measured segment durations.
// ----------------------------------------------------------------------------
// A segment that does not end a frame is accepted in the idle state and applied in
// the update state. A frame-ending segment then runs the shared tolerance unit
// through three multiply/compare steps, and the result write waits while an
// earlier result has not been taken. A new segment is accepted only once the
// previous one has been fully processed.
// Synchronous active-low reset restores default timings and clears the frame.
`default_nettype none

module nec_ir_pulse_decoder_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    nirdec_seg_if.sink                          i_seg,
    nirdec_res_if.source                        o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [nirdec_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);
    import nirdec_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration registers.
    nirdec_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer.
    nirdec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_seg.valid),
        .o_ready (i_seg.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath and result register.
    nirdec_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_segment_us (i_seg.segment_us),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_frame_ok   (o_res.frame_ok),
        .o_is_repeat  (o_res.is_repeat),
        .o_key_code   (o_res.key_code)
    );

endmodule : nec_ir_pulse_decoder_core

`default_nettype wire
